// File: rtl/sgp_pkg.sv
// Shared types, field widths and codes for the step sequencer gate player.
package sgp_pkg;

  localparam int MAX_STEPS_DEF = 64;
  localparam int TICK_BITS_DEF = 16;

  localparam int MODE_W     = 3;
  localparam int IDX_W      = 6;
  localparam int NOTE_W     = 7;
  localparam int VEL_W      = 7;
  localparam int CH_W       = 4;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int STEP_LEN_W = 16;
  localparam int PCT_W      = 7;
  localparam int SEQ_LEN_W  = 7;

  localparam logic [STEP_LEN_W-1:0] STEP_LEN_RST = 16'd6;
  localparam logic [PCT_W-1:0]      GATE_PCT_RST = 7'd50;
  localparam logic [SEQ_LEN_W-1:0]  SEQ_LEN_RST  = 7'd16;
  localparam logic [CH_W-1:0]       CHANNEL_RST  = 4'd0;

  // gate length = step_len * percent / 100, divide by reciprocal multiply
  localparam int PROD_W     = STEP_LEN_W + PCT_W;
  localparam int QUOT_W     = 17;
  localparam int RCP_W      = 24;
  localparam int RCP_SHIFT  = 30;
  localparam int RCP_PROD_W = PROD_W + RCP_W;
  localparam logic [RCP_W-1:0] GATE_RCP = 24'd10737419;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK    = 3'd0,
    MODE_PLAY    = 3'd1,
    MODE_PAUSE   = 3'd2,
    MODE_STOP    = 3'd3,
    MODE_SILENCE = 3'd4,
    MODE_WRITE   = 3'd5
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_LEN = 2'd0,
    CFG_GATE_PCT = 2'd1,
    CFG_SEQ_LEN  = 2'd2,
    CFG_CHANNEL  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic              active;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;
  } step_t;

  typedef struct packed {
    logic              is_note_on;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;
    logic [CH_W-1:0]   channel;
    logic              last;
  } event_t;

endpackage

// File: rtl/step_sequencer_gate_player_core.sv
// Step sequencer gate player: step store, playhead, gate timer and note event queue.
// Each event is written into the event queue when its input beat is accepted.
// Throughput: one input beat per cycle while the 4-entry event queue has two free slots.
// The gate length is recomputed by a two-stage multiply after reset and after
// every config write; input is held off meanwhile.
// Reset (rst, synchronous) clears control state; step store cleared by per-step valid bits.
module step_sequencer_gate_player_core #(
  parameter int MAX_STEPS = sgp_pkg::MAX_STEPS_DEF,
  parameter int TICK_BITS = sgp_pkg::TICK_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sgp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sgp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // step_index[5:0], step_active[6], step_note[13:7], step_velocity[20:14], zero pad
  input  logic [sgp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // mode[2:0]
  input  logic [sgp_pkg::MODE_W-1:0]       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // note[6:0], velocity[13:7], channel[17:14], zero pad
  output logic [sgp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // is_note_on[0]
  output logic                             m_axis_tuser,
  output logic                             m_axis_tlast
);
  import sgp_pkg::*;

  localparam int AW = (MAX_STEPS > 2) ? $clog2(MAX_STEPS) : 1;
  localparam int LW = (AW + 1 > SEQ_LEN_W) ? AW + 1 : SEQ_LEN_W;
  localparam int IW = (AW + 1 > IDX_W) ? AW + 1 : IDX_W;
  localparam int CW = (TICK_BITS > STEP_LEN_W) ? TICK_BITS : STEP_LEN_W;
  localparam int EW = (TICK_BITS > QUOT_W) ? TICK_BITS : QUOT_W;
  localparam logic [TICK_BITS-1:0] TICK_MAX = '1;
  localparam int OQ_CW = OQ_AW + 1;

  // config registers
  logic [STEP_LEN_W-1:0] step_len_ticks;
  logic [PCT_W-1:0]      gate_percent;
  logic [SEQ_LEN_W-1:0]  seq_length;
  logic [CH_W-1:0]       out_channel;
  logic                  cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_len_ticks <= STEP_LEN_RST;
      gate_percent   <= GATE_PCT_RST;
      seq_length     <= SEQ_LEN_RST;
      out_channel    <= CHANNEL_RST;
    end else if (cfg_fire) begin
      case (cfg_idx_t'(cfg_index))
        CFG_STEP_LEN: step_len_ticks <= cfg_data;
        CFG_GATE_PCT: gate_percent   <= cfg_data[PCT_W-1:0];
        CFG_SEQ_LEN:  seq_length     <= cfg_data[SEQ_LEN_W-1:0];
        CFG_CHANNEL:  out_channel    <= cfg_data[CH_W-1:0];
        default: ;
      endcase
    end
  end

  // gate length: multiply, then divide by 100 through a reciprocal multiply
  logic                  calc_load;
  logic                  calc_run;
  logic [PROD_W-1:0]     gate_prod;
  logic [RCP_PROD_W-1:0] gate_scaled;
  logic [QUOT_W-1:0]     gate_quot;
  logic [EW-1:0]         quot_ext;
  logic [TICK_BITS-1:0]  gate_len_calc;
  logic [TICK_BITS-1:0]  gate_len;

  assign gate_scaled = RCP_PROD_W'(gate_prod) * RCP_PROD_W'(GATE_RCP);
  assign gate_quot   = gate_scaled[RCP_SHIFT +: QUOT_W];
  assign quot_ext    = EW'(gate_quot);

  always_comb begin
    if (quot_ext == '0) begin
      gate_len_calc = TICK_BITS'(1);
    end else if (quot_ext > EW'(TICK_MAX)) begin
      gate_len_calc = TICK_MAX;
    end else begin
      gate_len_calc = quot_ext[TICK_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      calc_load <= 1'b1;
      calc_run  <= 1'b0;
    end else if (cfg_fire) begin
      calc_load <= 1'b1;
      calc_run  <= 1'b0;
    end else begin
      calc_load <= 1'b0;
      calc_run  <= calc_load;
    end
  end

  always_ff @(posedge clk) begin
    if (calc_load) begin
      gate_prod <= PROD_W'(step_len_ticks) * PROD_W'(gate_percent);
    end
    if (calc_run) begin
      gate_len <= gate_len_calc;
    end
  end

  // input decode
  logic              s_fire;
  mode_t             mode;
  logic [IW-1:0]     in_idx;
  step_t             in_step;

  assign s_fire  = s_axis_tvalid && s_axis_tready;
  assign mode    = mode_t'(s_axis_tuser);
  assign in_idx  = IW'(s_axis_tdata[5:0]);
  assign in_step = '{active: s_axis_tdata[6], note: s_axis_tdata[13:7],
                     velocity: s_axis_tdata[20:14]};

  // loop length and playhead advance
  logic [LW-1:0] seq_ext;
  logic [LW-1:0] seq_len_eff;

  assign seq_ext = LW'(seq_length);
  always_comb begin
    if (seq_ext == '0) begin
      seq_len_eff = LW'(1);
    end else if (seq_ext > LW'(MAX_STEPS)) begin
      seq_len_eff = LW'(MAX_STEPS);
    end else begin
      seq_len_eff = seq_ext;
    end
  end

  function automatic logic [AW-1:0] step_after(input logic [AW-1:0] p,
                                               input logic [LW-1:0] len);
    logic [LW-1:0] n;
    n = LW'(p) + LW'(1);
    if (n >= len) begin
      return '0;
    end
    return n[AW-1:0];
  endfunction

  // step store with prefetch of the current and the following step
  step_t                 step_mem [MAX_STEPS];
  logic [MAX_STEPS-1:0]  step_vld;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr_a;
  logic [AW-1:0]         rd_addr_b;
  step_t                 cur_step;
  step_t                 nxt_step;

  logic [AW-1:0]         playhead;
  logic [AW-1:0]         playhead_next;

  assign wr_en     = s_fire && (mode == MODE_WRITE) && (in_idx < IW'(MAX_STEPS));
  assign wr_addr   = in_idx[AW-1:0];
  assign rd_addr_a = playhead_next;
  assign rd_addr_b = step_after(playhead_next, seq_len_eff);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      step_mem[wr_addr] <= in_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_vld <= '0;
    end else if (wr_en) begin
      step_vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_addr == rd_addr_a) begin
      cur_step <= in_step;
    end else if (!step_vld[rd_addr_a]) begin
      cur_step <= '0;
    end else begin
      cur_step <= step_mem[rd_addr_a];
    end
    if (wr_en && wr_addr == rd_addr_b) begin
      nxt_step <= in_step;
    end else if (!step_vld[rd_addr_b]) begin
      nxt_step <= '0;
    end else begin
      nxt_step <= step_mem[rd_addr_b];
    end
  end

  // sequencer state
  logic [TICK_BITS-1:0] step_tick_count;
  logic [TICK_BITS-1:0] step_tick_count_next;
  logic [TICK_BITS-1:0] tick_inc;
  logic                 playing;
  logic                 playing_next;
  logic                 gate_sounding;
  logic                 gate_sounding_next;
  logic [NOTE_W-1:0]    gate_note;
  logic [NOTE_W-1:0]    gate_note_next;
  logic [TICK_BITS-1:0] gate_remaining;
  logic [TICK_BITS-1:0] gate_remaining_next;
  logic                 off_ev;
  logic                 on_ev;
  step_t                on_step;

  assign tick_inc = (step_tick_count == TICK_MAX) ? step_tick_count
                                                  : step_tick_count + TICK_BITS'(1);

  always_comb begin
    playhead_next        = playhead;
    step_tick_count_next = step_tick_count;
    playing_next         = playing;
    gate_sounding_next   = gate_sounding;
    gate_note_next       = gate_note;
    gate_remaining_next  = gate_remaining;
    off_ev               = 1'b0;
    on_ev                = 1'b0;
    on_step              = cur_step;
    if (s_fire) begin
      case (mode)
        MODE_TICK: begin
          if (gate_sounding) begin
            if (gate_remaining <= TICK_BITS'(1)) begin
              off_ev              = 1'b1;
              gate_sounding_next  = 1'b0;
              gate_remaining_next = '0;
            end else begin
              gate_remaining_next = gate_remaining - TICK_BITS'(1);
            end
          end
          if (playing) begin
            step_tick_count_next = tick_inc;
            if (CW'(tick_inc) >= CW'(step_len_ticks)) begin
              playhead_next        = step_after(playhead, seq_len_eff);
              step_tick_count_next = '0;
              if (gate_sounding_next) begin
                off_ev              = 1'b1;
                gate_sounding_next  = 1'b0;
                gate_remaining_next = '0;
              end
              if (nxt_step.active) begin
                on_ev               = 1'b1;
                on_step             = nxt_step;
                gate_sounding_next  = 1'b1;
                gate_note_next      = nxt_step.note;
                gate_remaining_next = gate_len;
              end
            end
          end
        end
        MODE_PLAY: begin
          if (!playing) begin
            playing_next = 1'b1;
            if (!gate_sounding) begin
              step_tick_count_next = '0;
              if (cur_step.active) begin
                on_ev               = 1'b1;
                gate_sounding_next  = 1'b1;
                gate_note_next      = cur_step.note;
                gate_remaining_next = gate_len;
              end
            end
          end
        end
        MODE_PAUSE: begin
          playing_next = 1'b0;
        end
        MODE_STOP: begin
          playing_next         = 1'b0;
          playhead_next        = '0;
          step_tick_count_next = '0;
          if (gate_sounding) begin
            off_ev              = 1'b1;
            gate_sounding_next  = 1'b0;
            gate_remaining_next = '0;
          end
        end
        MODE_SILENCE: begin
          if (gate_sounding) begin
            off_ev              = 1'b1;
            gate_sounding_next  = 1'b0;
            gate_remaining_next = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      playhead        <= '0;
      step_tick_count <= '0;
      playing         <= 1'b0;
      gate_sounding   <= 1'b0;
      gate_note       <= '0;
      gate_remaining  <= '0;
    end else begin
      playhead        <= playhead_next;
      step_tick_count <= step_tick_count_next;
      playing         <= playing_next;
      gate_sounding   <= gate_sounding_next;
      gate_note       <= gate_note_next;
      gate_remaining  <= gate_remaining_next;
    end
  end

  // event queue
  event_t             off_evt;
  event_t             on_evt;
  event_t             ev_a;
  event_t             ev_b;
  logic [OQ_AW-1:0]   push_n;
  logic               pop;
  event_t             oq [OQ_DEPTH];
  logic [OQ_AW-1:0]   oq_wp;
  logic [OQ_AW-1:0]   oq_rp;
  logic [OQ_CW-1:0]   oq_cnt;
  event_t             head;

  assign off_evt = '{is_note_on: 1'b0, note: gate_note, velocity: '0,
                     channel: out_channel, last: !on_ev};
  assign on_evt  = '{is_note_on: 1'b1, note: on_step.note, velocity: on_step.velocity,
                     channel: out_channel, last: 1'b1};

  always_comb begin
    ev_a   = on_evt;
    ev_b   = on_evt;
    push_n = '0;
    if (off_ev && on_ev) begin
      ev_a   = off_evt;
      push_n = OQ_AW'(2);
    end else if (off_ev) begin
      ev_a   = off_evt;
      push_n = OQ_AW'(1);
    end else if (on_ev) begin
      push_n = OQ_AW'(1);
    end
  end

  assign pop = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (push_n != '0) begin
      oq[oq_wp] <= ev_a;
    end
    if (push_n == OQ_AW'(2)) begin
      oq[oq_wp + OQ_AW'(1)] <= ev_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wp  <= '0;
      oq_rp  <= '0;
      oq_cnt <= '0;
    end else begin
      oq_wp  <= oq_wp + push_n;
      oq_rp  <= oq_rp + OQ_AW'(pop);
      oq_cnt <= oq_cnt + OQ_CW'(push_n) - OQ_CW'(pop);
    end
  end

  assign s_axis_tready = !calc_load && !calc_run && (oq_cnt <= OQ_CW'(OQ_DEPTH - 2));

  assign head          = oq[oq_rp];
  assign m_axis_tvalid = oq_cnt != '0;
  assign m_axis_tdata  = {{(OUT_DATA_W - NOTE_W - VEL_W - CH_W){1'b0}},
                          head.channel, head.velocity, head.note};
  assign m_axis_tuser  = head.is_note_on;
  assign m_axis_tlast  = head.last;

endmodule

// File: tb/step_sequencer_gate_player_core_test.sv
// Testbench for the step sequencer gate player: directed script, then random phases.
module step_sequencer_gate_player_core_test;
  import sgp_pkg::*;

  localparam int          IDLE_LIMIT   = 3000;
  localparam int          SETTLE_TICKS = 4;
  localparam int unsigned TICK_MAX     = (1 << TICK_BITS_DEF) - 1;
  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;
  localparam logic [1:0] CHK_MODEL = 2'd0;
  localparam logic [1:0] CHK_NONE  = 2'd1;
  localparam logic [1:0] CHK_ONE   = 2'd2;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [MODE_W-1:0]     s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;

  step_sequencer_gate_player_core uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
  );

  always #10 clk = ~clk;

  // predictor state
  int unsigned step_len_q, gate_pct_q, seq_len_q, channel_q;
  int unsigned play_pos, tick_cnt, gate_left;
  bit          running, gate_on;
  logic [NOTE_W-1:0] gate_key;
  step_t       steps [MAX_STEPS_DEF];

  event_t batch [$];
  event_t pending_notes [$];
  int     failures = 0;
  bit     calm = 1'b0;
  int     quiet_cycles = 0;
  int     stall_left = 0;

  function automatic void reset_model();
    step_len_q = 32'(STEP_LEN_RST);
    gate_pct_q = 32'(GATE_PCT_RST);
    seq_len_q  = 32'(SEQ_LEN_RST);
    channel_q  = 32'(CHANNEL_RST);
    play_pos = 0; tick_cnt = 0; gate_left = 0;
    running = 1'b0; gate_on = 1'b0; gate_key = '0;
    foreach (steps[i]) steps[i] = '0;
  endfunction

  function automatic int unsigned loop_len();
    if (seq_len_q < 1) return 1;
    if (seq_len_q > MAX_STEPS_DEF) return MAX_STEPS_DEF;
    return seq_len_q;
  endfunction

  function automatic void emit_note(bit on, logic [NOTE_W-1:0] key, logic [VEL_W-1:0] vel);
    event_t e;
    e.is_note_on = on;
    e.note       = key;
    e.velocity   = on ? vel : '0;
    e.channel    = channel_q[CH_W-1:0];
    e.last       = 1'b0;
    batch.push_back(e);
  endfunction

  function automatic void release_gate();
    if (gate_on) begin
      emit_note(1'b0, gate_key, '0);
      gate_on = 1'b0;
      gate_left = 0;
    end
  endfunction

  function automatic void start_step(int unsigned pos);
    step_t s;
    int unsigned len;
    release_gate();
    tick_cnt = 0;
    s = steps[pos % MAX_STEPS_DEF];
    if (s.active) begin
      emit_note(1'b1, s.note, s.velocity);
      len = (step_len_q * gate_pct_q) / 100;
      if (len < 1) len = 1;
      if (len > TICK_MAX) len = TICK_MAX;
      gate_on = 1'b1;
      gate_key = s.note;
      gate_left = len;
    end
  endfunction

  function automatic void predict_note_events(logic [MODE_W-1:0] m, logic [IDX_W-1:0] idx,
                                              logic act, logic [NOTE_W-1:0] key,
                                              logic [VEL_W-1:0] vel);
    int unsigned nxt;
    batch.delete();
    case (m)
      MODE_TICK: begin
        if (gate_on) begin
          if (gate_left <= 1) release_gate();
          else gate_left--;
        end
        if (running) begin
          if (tick_cnt < TICK_MAX) tick_cnt++;
          if (tick_cnt >= step_len_q) begin
            nxt = play_pos + 1;
            if (nxt >= loop_len()) nxt = 0;
            play_pos = nxt;
            start_step(play_pos);
          end
        end
      end
      MODE_PLAY: begin
        if (!running) begin
          running = 1'b1;
          if (!gate_on) start_step(play_pos);
        end
      end
      MODE_PAUSE: running = 1'b0;
      MODE_STOP: begin
        running = 1'b0;
        release_gate();
        play_pos = 0;
        tick_cnt = 0;
      end
      MODE_SILENCE: release_gate();
      MODE_WRITE: steps[idx] = {act, key, vel};
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endfunction

  task automatic send_event(logic [MODE_W-1:0] m, logic [IDX_W-1:0] idx, logic act,
                            logic [NOTE_W-1:0] key, logic [VEL_W-1:0] vel, bit use_model);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= m;
    s_axis_tdata  <= {3'b000, vel, key, act, idx};
    do @(posedge clk); while (!s_axis_tready);
    predict_note_events(m, idx, act, key, vel);
    if (use_model) foreach (batch[i]) pending_notes.push_back(batch[i]);
  endtask

  // lower tvalid, wait for every expected event, then let the block settle
  task automatic drain(int settle);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_notes.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic apply_settings(logic [15:0] len, logic [15:0] pct, logic [15:0] seq,
                                logic [15:0] ch);
    cfg_idx_t    order [4];
    logic [15:0] vals [4];
    order = '{CFG_STEP_LEN, CFG_GATE_PCT, CFG_SEQ_LEN, CFG_CHANNEL};
    vals  = '{len, pct, seq, ch};
    for (int r = 0; r < 4; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= order[r];
      cfg_data  <= vals[r];
      do @(posedge clk); while (!cfg_ready);
      case (order[r])
        CFG_STEP_LEN: step_len_q = 32'(vals[r][STEP_LEN_W-1:0]);
        CFG_GATE_PCT: gate_pct_q = 32'(vals[r][PCT_W-1:0]);
        CFG_SEQ_LEN:  seq_len_q  = 32'(vals[r][SEQ_LEN_W-1:0]);
        CFG_CHANNEL:  channel_q  = 32'(vals[r][CH_W-1:0]);
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_event();
    int r;
    logic [MODE_W-1:0] m;
    logic [IDX_W-1:0]  idx;
    r = $urandom_range(0, 99);
    if (r < 62)      m = MODE_TICK;
    else if (r < 79) m = MODE_WRITE;
    else if (r < 87) m = MODE_PLAY;
    else if (r < 91) m = MODE_PAUSE;
    else if (r < 94) m = MODE_STOP;
    else if (r < 97) m = MODE_SILENCE;
    else if (r < 98) m = MODE_SPARE_A;
    else             m = MODE_SPARE_B;
    if ($urandom_range(0, 4) != 0) idx = IDX_W'($urandom_range(0, loop_len() - 1));
    else idx = IDX_W'($urandom_range(0, MAX_STEPS_DEF - 1));
    send_event(m, idx, $urandom_range(0, 6) != 0, NOTE_W'($urandom_range(0, 127)),
               VEL_W'($urandom_range(0, 127)), 1'b1);
  endtask

  task automatic run_phase(int unsigned len, int unsigned pct, int unsigned seq,
                           int unsigned ch, int n_items, bit no_gaps);
    drain(SETTLE_TICKS);
    apply_settings(16'(len), 16'(pct), 16'(seq), 16'(ch));
    calm = no_gaps;
    // a paused playhead may now lie past the loop end
    send_event(MODE_SILENCE, '0, 1'b0, '0, '0, 1'b1);
    send_event(MODE_PLAY, '0, 1'b0, '0, '0, 1'b1);
    for (int n = 0; n < n_items; n++) begin
      if ($urandom_range(0, 49) == 0) drain(0);
      random_event();
    end
    send_event(MODE_PAUSE, '0, 1'b0, '0, '0, 1'b1);
  endtask

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  idx;
    logic              act;
    logic [NOTE_W-1:0] key;
    logic [VEL_W-1:0]  vel;
    logic [7:0]        reps;
    logic [1:0]        chk;
    logic              x_on;
    logic [NOTE_W-1:0] x_key;
    logic [VEL_W-1:0]  x_vel;
  } script_row_t;

  // reset settings: 6 ticks per step, gate of 3 ticks, 16 steps, channel 0
  script_row_t script [25] = '{
    '{MODE_TICK,    6'd0,  1'b0, 7'd0,   7'd0,   8'd1,  CHK_NONE,  1'b0, 7'd0,   7'd0},
    '{MODE_STOP,    6'd0,  1'b0, 7'd0,   7'd0,   8'd1,  CHK_NONE,  1'b0, 7'd0,   7'd0},
    '{MODE_SILENCE, 6'd0,  1'b0, 7'd0,   7'd0,   8'd1,  CHK_NONE,  1'b0, 7'd0,   7'd0},
    '{MODE_PAUSE,   6'd0,  1'b0, 7'd0,   7'd0,   8'd1,  CHK_NONE,  1'b0, 7'd0,   7'd0},
    '{MODE_WRITE,   6'd0,  1'b1, 7'd127, 7'd127, 8'd1,  CHK_NONE,  1'b0, 7'd0,   7'd0},
    '{MODE_WRITE,   6'd63, 1'b1, 7'd0,   7'd0,   8'd1,  CHK_NONE,  1'b0, 7'd0,   7'd0},
    '{MODE_WRITE,   6'd1,  1'b1, 7'd85,  7'd42,  8'd1,  CHK_NONE,  1'b0, 7'd0,   7'd0},
    '{MODE_WRITE,   6'd2,  1'b0, 7'd42,  7'd85,  8'd1,  CHK_NONE,  1'b0, 7'd0,   7'd0},
    '{MODE_SPARE_A, 6'd5,  1'b1, 7'd9,   7'd9,   8'd1,  CHK_NONE,  1'b0, 7'd0,   7'd0},
    '{MODE_SPARE_B, 6'd6,  1'b1, 7'd9,   7'd9,   8'd1,  CHK_NONE,  1'b0, 7'd0,   7'd0},
    '{MODE_PLAY,    6'd0,  1'b0, 7'd0,   7'd0,   8'd1,  CHK_ONE,   1'b1, 7'd127, 7'd127},
    '{MODE_PLAY,    6'd0,  1'b0, 7'd0,   7'd0,   8'd1,  CHK_NONE,  1'b0, 7'd0,   7'd0},
    '{MODE_TICK,    6'd0,  1'b0, 7'd0,   7'd0,   8'd3,  CHK_MODEL, 1'b0, 7'd0,   7'd0},
    '{MODE_TICK,    6'd0,  1'b0, 7'd0,   7'd0,   8'd3,  CHK_MODEL, 1'b0, 7'd0,   7'd0},
    '{MODE_PAUSE,   6'd0,  1'b0, 7'd0,   7'd0,   8'd1,  CHK_NONE,  1'b0, 7'd0,   7'd0},
    '{MODE_TICK,    6'd0,  1'b0, 7'd0,   7'd0,   8'd4,  CHK_MODEL, 1'b0, 7'd0,   7'd0},
    '{MODE_PLAY,    6'd0,  1'b0, 7'd0,   7'd0,   8'd1,  CHK_MODEL, 1'b0, 7'd0,   7'd0},
    '{MODE_PAUSE,   6'd0,  1'b0, 7'd0,   7'd0,   8'd1,  CHK_NONE,  1'b0, 7'd0,   7'd0},
    '{MODE_PLAY,    6'd0,  1'b0, 7'd0,   7'd0,   8'd1,  CHK_NONE,  1'b0, 7'd0,   7'd0},
    '{MODE_SILENCE, 6'd0,  1'b0, 7'd0,   7'd0,   8'd1,  CHK_ONE,   1'b0, 7'd85,  7'd0},
    '{MODE_TICK,    6'd0,  1'b0, 7'd0,   7'd0,   8'd6,  CHK_MODEL, 1'b0, 7'd0,   7'd0},
    '{MODE_WRITE,   6'd62, 1'b1, 7'd1,   7'd126, 8'd1,  CHK_NONE,  1'b0, 7'd0,   7'd0},
    '{MODE_STOP,    6'd0,  1'b0, 7'd0,   7'd0,   8'd1,  CHK_MODEL, 1'b0, 7'd0,   7'd0},
    '{MODE_PLAY,    6'd0,  1'b0, 7'd0,   7'd0,   8'd1,  CHK_MODEL, 1'b0, 7'd0,   7'd0},
    '{MODE_SILENCE, 6'd0,  1'b0, 7'd0,   7'd0,   8'd1,  CHK_MODEL, 1'b0, 7'd0,   7'd0}
  };

  // result side: random stalls and checking
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_notes.size() == 0) begin
        $error("unexpected note event: note %0d on %0d", m_axis_tdata[6:0], m_axis_tuser);
        failures++;
      end else begin
        event_t want;
        want = pending_notes.pop_front();
        compare_field("is_note_on", 32'(want.is_note_on), 32'(m_axis_tuser));
        compare_field("note", 32'(want.note), 32'(m_axis_tdata[6:0]));
        compare_field("velocity", 32'(want.velocity), 32'(m_axis_tdata[13:7]));
        compare_field("channel", 32'(want.channel), 32'(m_axis_tdata[17:14]));
        compare_field("last", 32'(want.last), 32'(m_axis_tlast));
      end
    end
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    reset_model();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < $size(script); i++) begin
      for (int k = 0; k < script[i].reps; k++)
        send_event(script[i].mode, script[i].idx, script[i].act, script[i].key,
                   script[i].vel, script[i].chk == CHK_MODEL);
      if (script[i].chk == CHK_ONE)
        pending_notes.push_back(event_t'({script[i].x_on, script[i].x_key, script[i].x_vel,
                                          4'd0, 1'b1}));
    end

    run_phase(6, 50, 16, 0, 80, 1'b0);
    run_phase(1, 0, 64, 15, 80, 1'b0);
    run_phase(0, 100, 1, 5, 60, 1'b1);
    run_phase(3, 127, 4, 9, 60, 1'b0);
    run_phase(65535, 127, 0, 3, 20, 1'b0);
    run_phase(2, 100, 100, 12, 80, 1'b0);
    run_phase(4, 33, 3, 7, 60, 1'b0);
    run_phase(65535, 100, 64, 10, 20, 1'b0);
    run_phase(1, 1, 2, 1, 60, 1'b0);
    run_phase($urandom_range(1, 8), $urandom_range(0, 127), $urandom_range(1, 64),
              $urandom_range(0, 15), 60, 1'b0);

    drain(SETTLE_TICKS * 2);
    if (pending_notes.size() != 0) begin
      $error("%0d note events never arrived", pending_notes.size());
      failures++;
    end
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/sgp_pkg.sv
rtl/step_sequencer_gate_player_core.sv
tb/step_sequencer_gate_player_core_test.sv
